@@ rtl/attn_pkg.sv @@
// Package for the 2x2 attention block: widths, payload structs and the
// elaboration-time softmax weight table built from exponentials. No dependencies.
`timescale 1ns / 1ps
package attn_pkg;

    localparam int FRAC_BITS       = 12;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int FIX_W   = 16;
    localparam int SCALE_W = 15;
    localparam int W_W     = FRAC_BITS + 1;
    localparam int RAW_W   = 2 * FIX_W + 1;
    localparam int PROD_W  = RAW_W + SCALE_W + 1;
    localparam int GAP_W   = PROD_W - 2 * FRAC_BITS + 1;
    localparam int UNIT_LOG = FRAC_BITS + 3;
    localparam int IDX_SHIFT = UNIT_LOG - $clog2(EXP_TABLE_DEPTH);
    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int MUL_W   = W_W + FIX_W + 1;
    localparam int ACC_W   = MUL_W + 1;

    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic [W_W-1:0] weight_t;

    typedef struct packed {
        fix_t [3:0] query;
        fix_t [3:0] key;
        fix_t [3:0] value;
    } att_in_t;

    // Per row: which column leads and how far the other trails it.
    typedef struct packed {
        logic [1:0]             lead;
        logic [1:0][GAP_W-1:0]  gap;
        fix_t [3:0]             value;
    } att_gap_t;

    typedef struct packed {
        weight_t [3:0] weight;
        fix_t [3:0]    value;
    } att_mix_t;

    // Restoring division, used only while building constant tables.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [SCALE_W-1:0] default_scale();
        longint unsigned target;
        longint unsigned root;
        longint unsigned t;
        target = 64'd1 << (2 * FRAC_BITS - 1);
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            if (t * t <= target)
                root = t;
        end
        if (4 * (root * root + root) + 1 < 4 * target)
            root = root + 1;
        return root[SCALE_W-1:0];
    endfunction

    localparam logic [SCALE_W-1:0] SCALE_RESET = default_scale();

    // Entry k holds {leader weight, trailing weight} for table index k;
    // the last entry covers every gap beyond the table.
    typedef logic [EXP_TABLE_DEPTH:0][2*W_W-1:0] wtab_t;

    function automatic wtab_t build_weights();
        wtab_t tab;
        longint unsigned x;
        longint unsigned term;
        longint signed r;
        longint unsigned c;
        longint unsigned e;
        longint unsigned sum;
        longint unsigned one;
        longint unsigned wl;
        longint unsigned wo;
        one = 64'd1 << FRAC_BITS;
        x = udiv((64'd1 << 33) + EXP_TABLE_DEPTH / 2, EXP_TABLE_DEPTH);
        term = 64'd1 << 30;
        r = 64'sd1 << 30;
        for (int n = 1; n <= 12; n++)
        begin
            term = udiv((term * x) >> 30, longint'(n));
            if (n % 2 == 1)
                r = r - longint'(term);
            else
                r = r + longint'(term);
        end
        c = 64'd1 << 30;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++)
        begin
            if (i > 0)
                c = (c * longint'(r) + (64'd1 << 29)) >> 30;
            if (i < EXP_TABLE_DEPTH)
                e = (c + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            else
                e = 0;
            sum = one + e;
            wl = udiv(one * one + (sum >> 1), sum);
            wo = udiv(e * one + (sum >> 1), sum);
            tab[i] = {wl[W_W-1:0], wo[W_W-1:0]};
        end
        return tab;
    endfunction

    localparam wtab_t WEIGHT_TABLE = build_weights();

endpackage

@@ rtl/attn_if.sv @@
// Channel interfaces for the attention block: request, response and the
// scale register write channel. Depends on attn_pkg.
`timescale 1ns / 1ps
interface attn_req_if
    import attn_pkg::*;
();
    logic valid;
    logic ready;
    fix_t query_00, query_01, query_10, query_11;
    fix_t key_00, key_01, key_10, key_11;
    fix_t value_00, value_01, value_10, value_11;

    modport source (output valid, query_00, query_01, query_10, query_11,
                    key_00, key_01, key_10, key_11,
                    value_00, value_01, value_10, value_11, input ready);
    modport sink (input valid, query_00, query_01, query_10, query_11,
                  key_00, key_01, key_10, key_11,
                  value_00, value_01, value_10, value_11, output ready);
endinterface

interface attn_rsp_if
    import attn_pkg::*;
();
    logic valid;
    logic ready;
    weight_t weight_00, weight_01, weight_10, weight_11;
    fix_t result_00, result_01, result_10, result_11;

    modport source (output valid, weight_00, weight_01, weight_10, weight_11,
                    result_00, result_01, result_10, result_11, input ready);
    modport sink (input valid, weight_00, weight_01, weight_10, weight_11,
                  result_00, result_01, result_10, result_11, output ready);
endinterface

interface attn_cfg_if
    import attn_pkg::*;
();
    logic valid;
    logic ready;
    logic [SCALE_W-1:0] score_scale;

    modport source (output valid, score_scale, input ready);
    modport sink (input valid, score_scale, output ready);
endinterface

@@ rtl/attention_2x2_forward.sv @@
// A request passes the score, softmax and mixing registers before its response.
// Throughput: one request per cycle; the score, softmax and mixing stages
// all advance together and hold while the response waits.
// Reset clears every valid bit and loads the scale register with
// one over the square root of two. Depends on attn_pkg, attn_if and the score, softmax and mix modules.
`timescale 1ns / 1ps
module attention_2x2_forward
    import attn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    attn_req_if.sink     req,
    attn_rsp_if.source   rsp,
    attn_cfg_if.sink     cfg
);
    logic [SCALE_W-1:0] scale_reg;
    logic     en;
    att_in_t  in_data;
    logic     gap_valid;
    att_gap_t gap_data;
    logic     mix_valid;
    att_mix_t mix_data;
    weight_t [3:0] weight;
    fix_t [3:0]    result;

    assign en = !rsp.valid || rsp.ready;
    assign req.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg.valid)
            scale_reg <= cfg.score_scale;
    end

    assign in_data.query = {req.query_11, req.query_10, req.query_01, req.query_00};
    assign in_data.key   = {req.key_11, req.key_10, req.key_01, req.key_00};
    assign in_data.value = {req.value_11, req.value_10, req.value_01, req.value_00};

    attn_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .in_data   (in_data),
        .scale     (scale_reg),
        .out_valid (gap_valid),
        .out_data  (gap_data)
    );

    attn_softmax u_softmax (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (gap_valid),
        .in_data   (gap_data),
        .out_valid (mix_valid),
        .out_data  (mix_data)
    );

    attn_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (mix_valid),
        .in_data    (mix_data),
        .out_valid  (rsp.valid),
        .out_weight (weight),
        .out_result (result)
    );

    assign rsp.weight_00 = weight[0];
    assign rsp.weight_01 = weight[1];
    assign rsp.weight_10 = weight[2];
    assign rsp.weight_11 = weight[3];
    assign rsp.result_00 = result[0];
    assign rsp.result_01 = result[1];
    assign rsp.result_10 = result[2];
    assign rsp.result_11 = result[3];
endmodule

@@ rtl/attn_score.sv @@
// Score stages: dot products Q*K^T, scaling, rounding and per-row leader
// and gap. Three register stages. Depends on attn_pkg.
`timescale 1ns / 1ps
module attn_score
    import attn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  att_in_t            in_data,
    input  logic [SCALE_W-1:0] scale,
    output logic               out_valid,
    output att_gap_t           out_data
);
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (2 * FRAC_BITS - 1);

    // Named signed element types keep every selected element signed.
    typedef logic signed [RAW_W-1:0]  raw_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [GAP_W-1:0]  score_t;

    logic [2:0] valid_reg;
    raw_t [3:0]  raw_reg;
    prod_t [3:0] prod_reg;
    fix_t [3:0] v1_reg;
    fix_t [3:0] v2_reg;
    att_gap_t gap_reg;

    raw_t [3:0]   raw_next;
    prod_t [3:0]  prod_next;
    score_t [3:0] score;
    att_gap_t gap_next;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                raw_next[i*2+j] = RAW_W'(in_data.query[i*2] * in_data.key[j*2])
                                + RAW_W'(in_data.query[i*2+1] * in_data.key[j*2+1]);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            prod_next[k] = PROD_W'(raw_reg[k] * $signed({1'b0, scale}));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            score[k] = GAP_W'((prod_reg[k] + HALF) >>> (2 * FRAC_BITS));
        end
        gap_next.value = v2_reg;
        for (int i = 0; i < 2; i++)
        begin
            gap_next.lead[i] = (score[i*2] >= score[i*2+1]) ? 1'b0 : 1'b1;
            if (gap_next.lead[i])
                gap_next.gap[i] = GAP_W'(score[i*2+1] - score[i*2]);
            else
                gap_next.gap[i] = GAP_W'(score[i*2] - score[i*2+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg  <= raw_next;
            v1_reg   <= in_data.value;
            prod_reg <= prod_next;
            v2_reg   <= v1_reg;
            gap_reg  <= gap_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = gap_reg;
endmodule

@@ rtl/attn_softmax.sv @@
// Softmax stage: turns each row's score gap into the two weights through
// the precomputed weight table. Depends on attn_pkg.
`timescale 1ns / 1ps
module attn_softmax
    import attn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  att_gap_t in_data,
    output logic     out_valid,
    output att_mix_t out_data
);
    localparam int SUM_W = GAP_W + 1;

    logic     valid_reg;
    att_mix_t mix_reg;
    att_mix_t mix_next;
    logic [SUM_W-1:0] idx_full;
    logic [IDX_W-1:0] idx;
    logic [2*W_W-1:0] pair;

    always_comb
    begin
        mix_next.value = in_data.value;
        idx_full = '0;
        idx = '0;
        pair = '0;
        for (int i = 0; i < 2; i++)
        begin
            idx_full = (SUM_W'(in_data.gap[i]) + SUM_W'(1 << (IDX_SHIFT - 1))) >> IDX_SHIFT;
            if (idx_full >= SUM_W'(EXP_TABLE_DEPTH))
                idx = IDX_W'(EXP_TABLE_DEPTH);
            else
                idx = idx_full[IDX_W-1:0];
            pair = WEIGHT_TABLE[idx];
            if (in_data.lead[i])
            begin
                mix_next.weight[i*2]   = pair[W_W-1:0];
                mix_next.weight[i*2+1] = pair[2*W_W-1:W_W];
            end
            else
            begin
                mix_next.weight[i*2]   = pair[2*W_W-1:W_W];
                mix_next.weight[i*2+1] = pair[W_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mix_reg <= mix_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = mix_reg;

    // Weight 0 of row 0 and weight 1 of row 1 never exceed one, and each
    // row's pair sums to one within a rounding step either way.
    a_w_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (mix_reg.weight[0] <= W_W'(1 << FRAC_BITS))
                   && (mix_reg.weight[3] <= W_W'(1 << FRAC_BITS)))
        else $error("weight above one");
    a_row0_sum: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((W_W+1)'(mix_reg.weight[0]) + mix_reg.weight[1]
                       <= (W_W+1)'((1 << FRAC_BITS) + 1))
                   && ((W_W+1)'(mix_reg.weight[0]) + mix_reg.weight[1]
                       >= (W_W+1)'((1 << FRAC_BITS) - 1)))
        else $error("row 0 weights do not sum to one");
    a_row1_sum: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((W_W+1)'(mix_reg.weight[2]) + mix_reg.weight[3]
                       <= (W_W+1)'((1 << FRAC_BITS) + 1))
                   && ((W_W+1)'(mix_reg.weight[2]) + mix_reg.weight[3]
                       >= (W_W+1)'((1 << FRAC_BITS) - 1)))
        else $error("row 1 weights do not sum to one");
endmodule

@@ rtl/attn_mix.sv @@
// Mixing stages: weights times V, rounding and saturation to 16 bits.
// Two register stages. Depends on attn_pkg.
`timescale 1ns / 1ps
module attn_mix
    import attn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  att_mix_t      in_data,
    output logic          out_valid,
    output weight_t [3:0] out_weight,
    output fix_t [3:0]    out_result
);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    // Named signed element type keeps every product signed when selected.
    typedef logic signed [MUL_W-1:0] mul_t;

    logic [1:0] valid_reg;
    mul_t [7:0] mul_reg;
    weight_t [3:0] w1_reg;
    weight_t [3:0] w2_reg;
    fix_t [3:0] res_reg;
    mul_t [7:0] mul_next;
    fix_t [3:0] res_next;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                mul_next[(i*2+j)*2]   = MUL_W'($signed({1'b0, in_data.weight[i*2]})
                                               * in_data.value[j]);
                mul_next[(i*2+j)*2+1] = MUL_W'($signed({1'b0, in_data.weight[i*2+1]})
                                               * in_data.value[2+j]);
            end
        end
    end

    always_comb
    begin
        acc = '0;
        rnd = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc = ACC_W'(mul_reg[k*2]) + ACC_W'(mul_reg[k*2+1]);
            rnd = (acc + HALF) >>> FRAC_BITS;
            if (rnd > SAT_HI)
                res_next[k] = 16'sh7fff;
            else if (rnd < SAT_LO)
                res_next[k] = 16'sh8000;
            else
                res_next[k] = rnd[FIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
            w1_reg  <= in_data.weight;
            w2_reg  <= w1_reg;
            res_reg <= res_next;
        end
    end

    assign out_valid  = valid_reg[1];
    assign out_weight = w2_reg;
    assign out_result = res_reg;
endmodule
